// ----- rtl/ils_pkg.sv -----
// Package for the indexed list store: sizes, command and status codes,
// print-sequencer states and the control bundle sent down the cell chain.
// Used by every file in rtl; depends on nothing.
package ils_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 6;
    localparam int OIDX_W   = 5;
    localparam int LEN_W    = 6;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_REVERSE = 2'd2,
        CMD_PRINT   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } stat_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_PRINT = 1'b1
    } state_t;

    // Broadcast to every cell: one shift command per cycle at most
    typedef struct packed {
        logic              ins_en;
        logic              del_en;
        logic [IDX_W-1:0]  at;
        logic [DATA_W-1:0] din;
    } cell_ctrl_t;

endpackage

// ----- rtl/ils_cell.sv -----
// One storage cell of the list chain: holds one element and takes its
// neighbor's value on insert (from below) or delete (from above).
// Depends on ils_pkg.
module ils_cell (
    input  logic                           clk,
    input  logic [ils_pkg::IDX_W-1:0]      cell_idx,
    input  ils_pkg::cell_ctrl_t            ctrl,
    input  logic [ils_pkg::DATA_W-1:0]     prev_val,
    input  logic [ils_pkg::DATA_W-1:0]     next_val,
    output logic [ils_pkg::DATA_W-1:0]     val
);

    logic [ils_pkg::DATA_W-1:0] val_reg;
    logic [ils_pkg::DATA_W-1:0] val_next;

    // Load at the insert point, shift up above it; shift down on delete
    always_comb
    begin
        val_next = val_reg;
        if (ctrl.ins_en)
        begin
            if (cell_idx == ctrl.at)
                val_next = ctrl.din;
            else if (cell_idx > ctrl.at)
                val_next = prev_val;
        end
        else if (ctrl.del_en)
        begin
            if (cell_idx >= ctrl.at)
                val_next = next_val;
        end
    end

    // Element payload: no reset needed
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ----- rtl/indexed_list_store.sv -----
// Top level of the indexed list store: command decode, cell chain,
// print sequencer and output register. Depends on ils_pkg and ils_cell.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: command, value,
//   position. Output channel (out_valid/out_ready) carries result items.
//   Insert, delete and reverse each give one result in the cycle after the
//   request is accepted; the cell chain shifts in that same edge, so a new
//   request can be accepted every cycle while the output is drained.
//   Print of N elements streams N results, one per cycle while the receiver
//   takes them, once the sequencer is in the print state; the element read
//   is a single mux over the cells addressed by the print counter. No request
//   is accepted until the last-flagged result is in the output register.
//   Print of an empty list gives one result with status empty.
//   Reset clears the element count, the reverse flag, the sequencer and
//   the output valid; cell contents stay undefined until written.
//   A stalled receiver holds the output register and freezes the print
//   stream and the input channel; nothing is lost or repeated.
//   Reverse only toggles a flag, which re-maps positions in the chain.
module indexed_list_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    command,
    input  logic signed [31:0]            value,
    input  logic [ils_pkg::POS_W-1:0]     position,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [31:0]            elem_value,
    output logic [ils_pkg::OIDX_W-1:0]    elem_index,
    output logic                          last,
    output logic [1:0]                    status,
    output logic [ils_pkg::LEN_W-1:0]     list_length
);

    localparam int CAP = ils_pkg::CAPACITY;
    localparam int DW  = ils_pkg::DATA_W;
    localparam int IW  = ils_pkg::IDX_W;
    localparam int CW  = ils_pkg::CNT_W;

    ils_pkg::state_t        state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   rev_reg, rev_next;
    logic [IW-1:0]          rd_idx_reg, rd_idx_next;
    logic [IW-1:0]          lg_idx_reg, lg_idx_next;

    logic                   out_valid_reg, out_valid_next;
    logic [DW-1:0]          oval_reg, oval_next;
    logic [ils_pkg::OIDX_W-1:0] oidx_reg, oidx_next;
    logic                   olast_reg, olast_next;
    ils_pkg::stat_t         ostat_reg, ostat_next;
    logic [ils_pkg::LEN_W-1:0] olen_reg, olen_next;

    ils_pkg::cmd_t          cmd;
    logic                   accept;
    logic                   out_free;
    logic                   ins_ok;
    logic                   del_ok;
    logic                   print_start;
    logic                   print_last;
    logic [CW-1:0]          pos_ext;
    logic [CW-1:0]          ins_at;
    logic [CW-1:0]          del_at;
    ils_pkg::stat_t         req_stat;
    ils_pkg::cell_ctrl_t    ctrl;
    logic [DW-1:0]          cell_val [CAP];

    assign cmd      = ils_pkg::cmd_t'(command);
    assign out_free = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Decode the request against the current count
    always_comb
    begin
        pos_ext  = CW'(position);
        ins_ok   = 1'b0;
        del_ok   = 1'b0;
        req_stat = ils_pkg::STAT_OK;
        case (cmd)
            ils_pkg::CMD_INSERT:
            begin
                if (position > ils_pkg::POS_W'(count_reg))
                    req_stat = ils_pkg::STAT_RANGE;
                else if (count_reg >= CW'(CAP))
                    req_stat = ils_pkg::STAT_FULL;
                else
                    ins_ok = 1'b1;
            end
            ils_pkg::CMD_DELETE:
            begin
                if (position >= ils_pkg::POS_W'(count_reg))
                    req_stat = ils_pkg::STAT_RANGE;
                else
                    del_ok = 1'b1;
            end
            ils_pkg::CMD_PRINT:
            begin
                if (count_reg == '0)
                    req_stat = ils_pkg::STAT_EMPTY;
            end
            default:
                req_stat = ils_pkg::STAT_OK;
        endcase
        ins_at = rev_reg ? (count_reg - pos_ext) : pos_ext;
        del_at = rev_reg ? (count_reg - CW'(1) - pos_ext) : pos_ext;
    end

    assign print_start = accept && (cmd == ils_pkg::CMD_PRINT) && (count_reg != '0);
    assign print_last  = (CW'(lg_idx_reg) == count_reg - CW'(1));

    // Drive the cell chain
    always_comb
    begin
        ctrl.ins_en = accept && ins_ok;
        ctrl.del_en = accept && del_ok;
        ctrl.at     = ins_ok ? ins_at[IW-1:0] : del_at[IW-1:0];
        ctrl.din    = DW'(value);
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAP; gi++)
        begin : g_cell
            logic [DW-1:0] prev_w;
            logic [DW-1:0] next_w;
            if (gi == 0)
            begin : g_first
                assign prev_w = '0;
            end
            else
            begin : g_prev
                assign prev_w = cell_val[gi-1];
            end
            if (gi == CAP - 1)
            begin : g_end
                assign next_w = '0;
            end
            else
            begin : g_next
                assign next_w = cell_val[gi+1];
            end
            ils_cell u_cell (
                .clk      (clk),
                .cell_idx (IW'(gi)),
                .ctrl     (ctrl),
                .prev_val (prev_w),
                .next_val (next_w),
                .val      (cell_val[gi])
            );
        end
    endgenerate

    // Next state of the print sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ils_pkg::ST_IDLE:
            begin
                if (print_start)
                    state_next = ils_pkg::ST_PRINT;
            end
            ils_pkg::ST_PRINT:
            begin
                if (out_free && print_last)
                    state_next = ils_pkg::ST_IDLE;
            end
            default:
                state_next = ils_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: list state, read pointers, result register
    always_comb
    begin
        in_ready       = 1'b0;
        count_next     = count_reg;
        rev_next       = rev_reg;
        rd_idx_next    = rd_idx_reg;
        lg_idx_next    = lg_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        oval_next      = oval_reg;
        oidx_next      = oidx_reg;
        olast_next     = olast_reg;
        ostat_next     = ostat_reg;
        olen_next      = olen_reg;
        case (state_reg)
            ils_pkg::ST_IDLE:
            begin
                in_ready = out_free;
                if (accept)
                begin
                    if (ins_ok)
                        count_next = count_reg + CW'(1);
                    else if (del_ok)
                        count_next = count_reg - CW'(1);
                    if (cmd == ils_pkg::CMD_REVERSE)
                        rev_next = !rev_reg;
                    rd_idx_next = rev_reg ? (count_reg[IW-1:0] - IW'(1)) : '0;
                    lg_idx_next = '0;
                    if (!print_start)
                    begin
                        out_valid_next = 1'b1;
                        oval_next      = '0;
                        oidx_next      = '0;
                        olast_next     = 1'b1;
                        ostat_next     = req_stat;
                        olen_next      = ils_pkg::LEN_W'(count_next);
                    end
                end
            end
            ils_pkg::ST_PRINT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    oval_next      = cell_val[rd_idx_reg];
                    oidx_next      = ils_pkg::OIDX_W'(lg_idx_reg);
                    olast_next     = print_last;
                    ostat_next     = ils_pkg::STAT_OK;
                    olen_next      = ils_pkg::LEN_W'(count_reg);
                    lg_idx_next    = lg_idx_reg + IW'(1);
                    rd_idx_next    = rev_reg ? (rd_idx_reg - IW'(1))
                                             : (rd_idx_reg + IW'(1));
                end
            end
            default:
                in_ready = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ils_pkg::ST_IDLE;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pointers and result payload
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        lg_idx_reg <= lg_idx_next;
        oval_reg   <= oval_next;
        oidx_reg   <= oidx_next;
        olast_reg  <= olast_next;
        ostat_reg  <= ostat_next;
        olen_reg   <= olen_next;
    end

    assign out_valid   = out_valid_reg;
    assign elem_value  = $signed(oval_reg);
    assign elem_index  = oidx_reg;
    assign last        = olast_reg;
    assign status      = ostat_reg;
    assign list_length = olen_reg;

endmodule

// ----- rtl/ils_checker.sv -----
// Port-level checker for the indexed list store, bound to the top level.
// Depends on ils_pkg and on the port names of indexed_list_store.
module ils_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          last,
    input  logic [1:0]                    status,
    input  logic [ils_pkg::LEN_W-1:0]     list_length
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Error and empty results always close their request
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ils_pkg::STAT_OK) |-> last)
        else $error("non-ok status without last");

    // Empty status only with an empty list
    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ils_pkg::STAT_EMPTY) |-> (list_length == '0))
        else $error("empty status with nonzero length");

    // Advance a print stream with no gap and a steady length
    a_stream: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=>
            out_valid && (list_length == $past(list_length)))
        else $error("print stream broken");

endmodule

bind indexed_list_store ils_checker u_ils_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .last        (last),
    .status      (status),
    .list_length (list_length)
);

// ----- bench/indexed_list_store_tb.sv -----
`timescale 1ns / 100ps
// Testbench for indexed_list_store: a scoreboard class predicts each result from the
// accepted request, and plain tasks drive directed then random requests under random idling.
// Depends on ils_pkg and the indexed_list_store RTL.
module indexed_list_store_tb;

    import ils_pkg::*;

    localparam int MAX_REPORTS    = 10;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        logic signed [DATA_W-1:0] elem_value;
        logic [OIDX_W-1:0]        elem_index;
        logic                     last;
        stat_t                    status;
        logic [LEN_W-1:0]         list_length;
    } list_result_t;

    // Keep a shadow copy of the list and the results that each request should give
    class list_scoreboard;
        logic signed [DATA_W-1:0] cells [CAPACITY];
        int                       fill;
        bit                       flipped;
        list_result_t             pending_results [$];
        int                       failures;

        function new();
            fill     = 0;
            flipped  = 1'b0;
            failures = 0;
        endfunction

        // Map a list position to its slot; reverse only flips the mapping
        function int slot_of(int logical);
            return flipped ? (fill - 1 - logical) : logical;
        endfunction

        function void push_result(logic signed [DATA_W-1:0] v, int idx, bit lst, stat_t st);
            list_result_t r;
            r.elem_value  = v;
            r.elem_index  = idx[OIDX_W-1:0];
            r.last        = lst;
            r.status      = st;
            r.list_length = fill[LEN_W-1:0];
            pending_results.push_back(r);
        endfunction

        // Apply an accepted request to the shadow list and queue its results
        function void note_request(cmd_t cmd, logic signed [DATA_W-1:0] val,
                                   logic [POS_W-1:0] pos);
            stat_t st;
            int    at;
            st = STAT_OK;
            case (cmd)
                CMD_INSERT:
                begin
                    if (pos > fill)
                        st = STAT_RANGE;
                    else if (fill >= CAPACITY)
                        st = STAT_FULL;
                    else
                    begin
                        at = flipped ? (fill - pos) : pos;
                        for (int i = fill; i > at; i--)
                            cells[i] = cells[i - 1];
                        cells[at] = val;
                        fill++;
                    end
                end
                CMD_DELETE:
                begin
                    if (pos >= fill)
                        st = STAT_RANGE;
                    else
                    begin
                        at = slot_of(pos);
                        for (int i = at; i + 1 < fill; i++)
                            cells[i] = cells[i + 1];
                        fill--;
                    end
                end
                CMD_REVERSE:
                    flipped = !flipped;
                default:
                begin
                    // Print streams every element, or one empty-status result
                    if (fill == 0)
                        push_result('0, 0, 1'b1, STAT_EMPTY);
                    else
                        for (int i = 0; i < fill; i++)
                            push_result(cells[slot_of(i)], i, (i + 1 == fill), STAT_OK);
                    return;
                end
            endcase
            push_result('0, 0, 1'b1, st);
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(logic signed [DATA_W-1:0] v, logic [OIDX_W-1:0] idx,
                                   logic lst, logic [1:0] st, logic [LEN_W-1:0] len);
            list_result_t want;
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result: value %0d index %0d last %0b status %0d len %0d",
                             v, idx, lst, st, len);
                return;
            end
            want = pending_results.pop_front();
            if (v !== want.elem_value || idx !== want.elem_index || lst !== want.last ||
                st !== want.status || len !== want.list_length)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                begin
                    $display("mismatch: expected value %0d index %0d last %0b status %0d len %0d",
                             want.elem_value, want.elem_index, want.last, want.status,
                             want.list_length);
                    $display("          actual   value %0d index %0d last %0b status %0d len %0d",
                             v, idx, lst, st, len);
                end
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic [1:0]               command   = CMD_INSERT;
    logic signed [DATA_W-1:0] value     = '0;
    logic [POS_W-1:0]         position  = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] elem_value;
    logic [OIDX_W-1:0]        elem_index;
    logic                     last;
    logic [1:0]               status;
    logic [LEN_W-1:0]         list_length;

    list_scoreboard sb;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             idle_cycles = 0;

    indexed_list_store DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .value       (value),
        .position    (position),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .elem_value  (elem_value),
        .elem_index  (elem_index),
        .last        (last),
        .status      (status),
        .list_length (list_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Check accepted results, then stall the output at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(elem_value, elem_index, last, status, list_length);
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // End the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Offer one request, with random idle cycles first, and hold it until accepted
    task automatic send_request(cmd_t cmd, logic signed [DATA_W-1:0] val,
                                logic [POS_W-1:0] pos);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= val;
        position <= pos;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(cmd, val, pos);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -1;
            default: return $urandom();
        endcase
    endfunction

    // Issue random requests; the weights steer the list toward full or empty
    task automatic run_segment(int n, int ins_w, int del_w);
        int   r;
        cmd_t cmd;
        int   pos;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < ins_w)
            begin
                cmd = CMD_INSERT;
                pos = ($urandom_range(0, 9) != 0) ? $urandom_range(0, sb.fill)
                                                  : $urandom_range(0, 32);
            end
            else if (r < ins_w + del_w)
            begin
                cmd = CMD_DELETE;
                pos = (sb.fill > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, sb.fill - 1)
                                                                : $urandom_range(0, 32);
            end
            else
            begin
                cmd = $urandom_range(0, 1) ? CMD_REVERSE : CMD_PRINT;
                pos = $urandom_range(0, 32);
            end
            send_request(cmd, pick_value(), pos[POS_W-1:0]);
        end
    endtask

    task automatic run_random_phase();
        run_segment(50, 84, 4);
        run_segment(45, 4, 84);
        run_segment(12, 40, 35);
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 10;
        recv_idle_pct = 78;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, range errors, extreme values, reverse mapping
        send_request(CMD_PRINT,   0, 0);
        send_request(CMD_DELETE,  0, 0);
        send_request(CMD_REVERSE, 0, 0);
        send_request(CMD_INSERT,  5, 1);
        send_request(CMD_INSERT,  32'sh8000_0000, 0);
        send_request(CMD_INSERT,  32'sh7FFF_FFFF, 1);
        send_request(CMD_INSERT,  -1, 1);
        send_request(CMD_INSERT,  0, 32);
        send_request(CMD_PRINT,   0, 0);
        send_request(CMD_REVERSE, 0, 0);
        send_request(CMD_PRINT,   0, 0);
        send_request(CMD_INSERT,  32'sh5A5A_5A5A, 3);
        send_request(CMD_DELETE,  0, 0);
        send_request(CMD_DELETE,  0, 2);
        send_request(CMD_DELETE,  0, 31);
        send_request(CMD_DELETE,  0, 2);
        send_request(CMD_INSERT,  32'sh0000_0001, 0);
        send_request(CMD_PRINT,   0, 0);

        run_random_phase();
        send_idle_pct = 78;
        recv_idle_pct = 10;
        run_random_phase();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase();
        in_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
